### rtl/erif_pkg.sv
package erif_pkg;

    // Default number of bank items that make up one tick at most
    localparam int ERIF_MAX_BANKS = 2;

    // Field widths
    localparam int RPM_W   = 16;
    localparam int POS_W   = 16;
    localparam int DELTA_W = 24;
    localparam int TIME_W  = 40;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 88;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;

    // Register indexes (byte address divided by four)
    typedef enum logic [2:0] {
        REG_RUNUP_RPM_LOW  = 3'd0,
        REG_RUNUP_RPM_HIGH = 3'd1,
        REG_POS_THR_LOW    = 3'd2,
        REG_POS_THR_HIGH   = 3'd3,
        REG_POS_CHECK_EN   = 3'd4
    } reg_index_t;

    // Reset values of the configuration registers
    localparam logic [RPM_W-1:0] RUNUP_RPM_LOW_RST  = 16'd300;
    localparam logic [RPM_W-1:0] RUNUP_RPM_HIGH_RST = 16'd400;
    localparam logic [POS_W-1:0] POS_THR_LOW_RST    = 16'd0;
    localparam logic [POS_W-1:0] POS_THR_HIGH_RST   = 16'd0;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [RPM_W-1:0] runup_rpm_low;
        logic [RPM_W-1:0] runup_rpm_high;
        logic [POS_W-1:0] pos_thr_low;
        logic [POS_W-1:0] pos_thr_high;
        logic             pos_check_enabled;
    } cfg_t;

    // One bank item
    typedef struct packed {
        logic               bank_last;
        logic [DELTA_W-1:0] time_delta_us;
        logic               crank_valid;
        logic [RPM_W-1:0]   crank_rpm;
        logic [POS_W-1:0]   pos_value;
        logic               pos_valid;
        logic [RPM_W-1:0]   bank_rpm;
        logic               bank_rpm_valid;
        logic [RPM_W-1:0]   idle_rpm_thr_low;
        logic [RPM_W-1:0]   idle_rpm_thr_high;
        logic               idle_rpm_thr_valid;
    } item_t;

    // One result item
    typedef struct packed {
        logic              runup_out;
        logic              idle_out;
        logic              econ_idle_out;
        logic              pos_idle_out;
        logic              rpm_idle_out;
        logic [TIME_W-1:0] run_time_current_us;
        logic [TIME_W-1:0] run_time_total_us;
    } result_t;

endpackage

### rtl/erif_cfg.sv
module erif_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [erif_pkg::ADDR_W-1:0] paddr,
    input  logic [erif_pkg::APB_W-1:0]  pwdata,
    output logic [erif_pkg::APB_W-1:0]  prdata,
    output erif_pkg::cfg_t              cfg
);
    import erif_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_RUNUP_RPM_LOW:  cfg_next.runup_rpm_low     = pwdata[RPM_W-1:0];
                REG_RUNUP_RPM_HIGH: cfg_next.runup_rpm_high    = pwdata[RPM_W-1:0];
                REG_POS_THR_LOW:    cfg_next.pos_thr_low       = pwdata[POS_W-1:0];
                REG_POS_THR_HIGH:   cfg_next.pos_thr_high      = pwdata[POS_W-1:0];
                REG_POS_CHECK_EN:   cfg_next.pos_check_enabled = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.runup_rpm_low     <= RUNUP_RPM_LOW_RST;
            cfg_reg.runup_rpm_high    <= RUNUP_RPM_HIGH_RST;
            cfg_reg.pos_thr_low       <= POS_THR_LOW_RST;
            cfg_reg.pos_thr_high      <= POS_THR_HIGH_RST;
            cfg_reg.pos_check_enabled <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back of the register selected by the address
    always_comb
    begin
        unique case (index)
            REG_RUNUP_RPM_LOW:  prdata = APB_W'(cfg_reg.runup_rpm_low);
            REG_RUNUP_RPM_HIGH: prdata = APB_W'(cfg_reg.runup_rpm_high);
            REG_POS_THR_LOW:    prdata = APB_W'(cfg_reg.pos_thr_low);
            REG_POS_THR_HIGH:   prdata = APB_W'(cfg_reg.pos_thr_high);
            REG_POS_CHECK_EN:   prdata = APB_W'(cfg_reg.pos_check_enabled);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/erif_core.sv
module erif_core #(
    parameter int MAX_BANKS = erif_pkg::ERIF_MAX_BANKS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  erif_pkg::cfg_t    cfg,
    input  erif_pkg::item_t   item,
    input  logic              advance,
    output logic              emit,
    output erif_pkg::result_t result
);
    import erif_pkg::*;

    localparam int CNT_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Flags and times carried from tick to tick
    logic              runup_reg;
    logic              pos_idle_reg;
    logic              rpm_idle_reg;
    logic [TIME_W-1:0] time_cur_reg;
    logic [TIME_W-1:0] time_tot_reg;
    logic              pos_ok_reg;
    logic              rpm_ok_reg;
    logic              mid_tick_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              first;
    logic              runup_next;
    logic              rpm_idle_eff;
    logic [TIME_W-1:0] time_cur_next;
    logic [TIME_W-1:0] time_tot_next;
    logic              pos_ok_next;
    logic              rpm_ok_next;
    logic [POS_W-1:0]  pos_thr;
    logic [RPM_W-1:0]  rpm_thr;
    logic [CNT_W-1:0]  count_cur;
    logic              tick_end;

    // Saturating add of a time delta to a run time
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DELTA_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W+1)'(d);
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    assign first = !mid_tick_reg;

    // Run-up hysteresis and run times, evaluated on the tick's first item
    always_comb
    begin
        runup_next = runup_reg;
        if (first)
        begin
            if (!item.crank_valid)
                runup_next = 1'b0;
            else if (item.crank_rpm > cfg.runup_rpm_high)
                runup_next = 1'b1;
            else if (item.crank_rpm < cfg.runup_rpm_low)
                runup_next = 1'b0;
        end

        time_cur_next = time_cur_reg;
        time_tot_next = time_tot_reg;
        rpm_idle_eff  = rpm_idle_reg;
        if (first)
        begin
            if (runup_next)
            begin
                time_cur_next = sat_add(time_cur_reg, item.time_delta_us);
                time_tot_next = sat_add(time_tot_reg, item.time_delta_us);
            end
            else
            begin
                time_cur_next = '0;
                rpm_idle_eff  = 1'b0;
            end
        end
    end

    // Per-bank idle tests, ANDed into the tick's accumulators
    assign pos_thr = pos_idle_reg ? cfg.pos_thr_high : cfg.pos_thr_low;
    assign rpm_thr = rpm_idle_eff ? item.idle_rpm_thr_high : item.idle_rpm_thr_low;

    assign pos_ok_next = (first || pos_ok_reg) && cfg.pos_check_enabled && item.pos_valid
                         && (item.pos_value <= pos_thr);
    assign rpm_ok_next = (first || rpm_ok_reg) && item.bank_rpm_valid
                         && item.idle_rpm_thr_valid && (item.bank_rpm <= rpm_thr);

    // Bank counting; the last permitted bank closes the tick on its own
    assign count_cur = first ? '0 : count_reg;
    assign tick_end  = item.bank_last || (count_cur == CNT_W'(MAX_BANKS - 1));
    assign emit      = tick_end;

    always_comb
    begin
        result.runup_out           = runup_next;
        result.idle_out            = runup_next && pos_ok_next && rpm_ok_next;
        result.econ_idle_out       = runup_next && pos_ok_next && !rpm_ok_next;
        result.pos_idle_out        = pos_ok_next;
        result.rpm_idle_out        = rpm_ok_next;
        result.run_time_current_us = time_cur_next;
        result.run_time_total_us   = time_tot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runup_reg    <= 1'b0;
            pos_idle_reg <= 1'b0;
            rpm_idle_reg <= 1'b0;
            time_cur_reg <= '0;
            time_tot_reg <= '0;
            pos_ok_reg   <= 1'b1;
            rpm_ok_reg   <= 1'b1;
            mid_tick_reg <= 1'b0;
            count_reg    <= '0;
        end
        else if (advance)
        begin
            runup_reg    <= runup_next;
            time_cur_reg <= time_cur_next;
            time_tot_reg <= time_tot_next;
            pos_ok_reg   <= pos_ok_next;
            rpm_ok_reg   <= rpm_ok_next;
            if (tick_end)
            begin
                pos_idle_reg <= pos_ok_next;
                rpm_idle_reg <= rpm_ok_next;
                mid_tick_reg <= 1'b0;
                count_reg    <= '0;
            end
            else
            begin
                rpm_idle_reg <= rpm_idle_eff;
                mid_tick_reg <= 1'b1;
                count_reg    <= count_cur + 1'b1;
            end
        end
    end

endmodule

### rtl/engine_runup_idle_flags.sv
// Engine run-up and idle flag block.
//
// Bank items arrive on the s_ stream, one per bank; s_tlast marks the last
// bank item of a calculation tick. The first item of a tick updates the
// run-up flag and the run times, every item contributes its position and rpm
// idle tests, and the item that closes the tick (s_tlast, or the MAX_BANKS-th
// bank) produces one result item on the m_ stream. Other items produce none.
// Thresholds and the position check enable must be written over the APB port
// only while idle, which the block does not enforce; pready is always high.
//
// An accepted item is held in the input register, and the result of the item
// that closes a tick is registered in the output register, from which it is
// offered on the m_ stream. One item is accepted every cycle unless a closing
// item is held back by a waiting result; the limit is the single state update
// per cycle in the flag logic.
// If m_tready is held low with a result waiting, items that produce no result
// still go through; the next closing item waits in the input register and
// s_tready drops until the waiting result is taken.
// Reset clears all flags and run times and returns the configuration
// registers to their defaults.
module engine_runup_idle_flags #(
    parameter int MAX_BANKS = erif_pkg::ERIF_MAX_BANKS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Bank items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // time_delta_us[23:0], crank_valid[24], crank_rpm[40:25], pos_value[56:41],
    // pos_valid[57], bank_rpm[73:58], bank_rpm_valid[74],
    // idle_rpm_thr_low[90:75], idle_rpm_thr_high[106:91],
    // idle_rpm_thr_valid[107], zero fill[111:108]
    input  logic [erif_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // runup_out[0], idle_out[1], econ_idle_out[2], pos_idle_out[3],
    // rpm_idle_out[4], run_time_current_us[44:5], run_time_total_us[84:45],
    // zero fill[87:85]
    output logic [erif_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [erif_pkg::ADDR_W-1:0]     paddr,
    input  logic [erif_pkg::APB_W-1:0]      pwdata,
    output logic [erif_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);
    import erif_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    core_emit;
    logic    advance;
    logic    out_free;
    logic    s_accept;

    assign pready = 1'b1;

    erif_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Unpack the incoming item
    always_comb
    begin
        s_item.bank_last          = s_tlast;
        s_item.time_delta_us      = s_tdata[23:0];
        s_item.crank_valid        = s_tdata[24];
        s_item.crank_rpm          = s_tdata[40:25];
        s_item.pos_value          = s_tdata[56:41];
        s_item.pos_valid          = s_tdata[57];
        s_item.bank_rpm           = s_tdata[73:58];
        s_item.bank_rpm_valid     = s_tdata[74];
        s_item.idle_rpm_thr_low   = s_tdata[90:75];
        s_item.idle_rpm_thr_high  = s_tdata[106:91];
        s_item.idle_rpm_thr_valid = s_tdata[107];
    end

    // The held item moves on unless it closes a tick and the result slot is full
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!core_emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    erif_core #(
        .MAX_BANKS (MAX_BANKS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (in_item_reg),
        .advance (advance),
        .emit    (core_emit),
        .result  (core_result)
    );

    // Input register
    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_item_reg <= s_item;
    end

    // Output register
    assign out_valid_next = (advance && core_emit) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_emit)
            out_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.run_time_total_us,
                       out_reg.run_time_current_us,
                       out_reg.rpm_idle_out,
                       out_reg.pos_idle_out,
                       out_reg.econ_idle_out,
                       out_reg.idle_out,
                       out_reg.runup_out};

    // The current run time never runs ahead of the total run time.
    a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.run_time_current_us <= out_reg.run_time_total_us))
        else $error("current run time exceeds total run time");

    // Idle and economy idle exclude each other and both need run-up.
    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.idle_out && out_reg.econ_idle_out))
        else $error("idle and economy idle both set");

    a_idle_runup: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.idle_out || out_reg.econ_idle_out)) |-> out_reg.runup_out)
        else $error("idle flag set without run-up");

    // A closing item is held back only while a result waits to be taken.
    a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (core_emit && out_valid_reg && !m_tready))
        else $error("held item stalled without a waiting result");

    // A new result is only loaded into a free output slot.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_emit) |-> out_free)
        else $error("result overwritten before it was taken");

endmodule
